>>> src/circle_point_derivative_eval_macros.svh
// assertion macros for the circle evaluation block
// no dependencies; included by the top level only
`ifndef CIRCLE_POINT_DERIVATIVE_EVAL_MACROS_SVH
`define CIRCLE_POINT_DERIVATIVE_EVAL_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CPDE_ASSERT_NOW(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error("cpde check failed");

// next-cycle implication, disabled while reset is low
`define CPDE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error("cpde check failed");

`endif

>>> src/cpde_pkg.sv
// shared types, constants and functions of the circle evaluation block
// no dependencies
`default_nettype none

package cpde_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int MAX_ORDER    = 63;
  localparam int DIV_STEPS    = 48;
  localparam int CNT_W        = $clog2(DIV_STEPS);
  localparam int ITER_W       = 5;
  localparam int IDX_W        = 6;
  localparam int ORD_W        = 7;
  localparam int ANG_W        = 16;
  localparam int VEC_W        = 32;
  localparam int AXIS_W       = 48;
  localparam int RAD_W        = 32;
  localparam int CS_W         = 34;
  localparam int TRIG_W       = 35;
  localparam int COEF_W       = 36;
  localparam int PROD_W       = 52;
  localparam int WIDE_W       = 49;

  localparam logic [30:0] PI_Q29   = 31'd1686629713;
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  localparam logic [1:0] ACT_POINT = 2'd0;
  localparam logic [1:0] ACT_TANG  = 2'd1;
  localparam logic [1:0] ACT_DERIV = 2'd2;
  localparam logic [1:0] ACT_CURV  = 2'd3;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_RAD = 2'd1;
  localparam logic [1:0] ST_ORD = 2'd2;

  // coefficient pairs (a, b) for a*X + b*Y
  localparam logic [1:0] SEL_CS   = 2'd0;
  localparam logic [1:0] SEL_NSC  = 2'd1;
  localparam logic [1:0] SEL_NCNS = 2'd2;
  localparam logic [1:0] SEL_SNC  = 2'd3;

  localparam logic [1:0] SRC_ZERO = 2'd0;
  localparam logic [1:0] SRC_COMB = 2'd1;
  localparam logic [1:0] SRC_QUO  = 2'd2;

  localparam logic [2:0] CFG_CX  = 3'd0;
  localparam logic [2:0] CFG_CY  = 3'd1;
  localparam logic [2:0] CFG_CZ  = 3'd2;
  localparam logic [2:0] CFG_AX  = 3'd3;
  localparam logic [2:0] CFG_AY  = 3'd4;
  localparam logic [2:0] CFG_RAD = 3'd5;

  typedef struct packed {
    logic signed [VEC_W-1:0] cx;
    logic signed [VEC_W-1:0] cy;
    logic signed [VEC_W-1:0] cz;
    logic [AXIS_W-1:0]       ax;
    logic [AXIS_W-1:0]       ay;
    logic [RAD_W-1:0]        rad;
  } cfg_t;

  typedef struct packed {
    logic              load;
    logic              cstep;
    logic [ITER_W-1:0] iter;
    logic              scale;
    logic              mul;
    logic              cmul;
    logic [1:0]        sel;
    logic              dinit;
    logic              dstep;
    logic              oload;
    logic [1:0]        src;
    logic              center;
    logic [IDX_W-1:0]  idx;
    logic              last;
    logic [1:0]        status;
  } cmd_t;

  typedef struct packed {
    logic rad_zero;
    logic out_busy;
  } sts_t;

  function automatic logic [30:0] atan_q30(input logic [ITER_W-1:0] i);
    unique case (i)
      5'd0:    return 31'd843314857;
      5'd1:    return 31'd497837829;
      5'd2:    return 31'd263043837;
      5'd3:    return 31'd133525159;
      5'd4:    return 31'd67021687;
      5'd5:    return 31'd33543516;
      5'd6:    return 31'd16775851;
      5'd7:    return 31'd8388437;
      5'd8:    return 31'd4194283;
      5'd9:    return 31'd2097149;
      5'd10:   return 31'd1048576;
      default: return 31'(32'h4000_0000 >> i);
    endcase
  endfunction

  function automatic logic [VEC_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v > 49'sd2147483647) return 32'h7fff_ffff;
    if (v < -49'sd2147483648) return 32'h8000_0000;
    return v[VEC_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> src/cpde_ctrl.sv
// sequencer of the circle evaluation block
// depends on cpde_pkg
`default_nettype none

module cpde_ctrl import cpde_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [1:0]       action,
  input  wire logic [ORD_W-1:0] order,
  input  wire sts_t             sts,
  output cmd_t                  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CORD  = 3'd1;
  localparam logic [2:0] S_SCALE = 3'd2;
  localparam logic [2:0] S_DISP  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_PUT   = 3'd5;
  localparam logic [2:0] S_DINIT = 3'd6;
  localparam logic [2:0] S_DIV   = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [1:0]       act_r, act_nxt;
  logic [ORD_W-1:0] ord_r, ord_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [1:0]       sel_r, sel_nxt;
  logic             center_r, center_nxt;
  logic             last_r, last_nxt;
  logic [1:0]       status_r, status_nxt;
  logic [1:0]       src_r, src_nxt;
  logic             ord_bad;

  assign ord_bad = ord_r[ORD_W-1] || (ord_r[IDX_W-1:0] > IDX_W'(MAX_ORDER));
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    act_nxt    = act_r;
    ord_nxt    = ord_r;
    k_nxt      = k_r;
    sel_nxt    = sel_r;
    center_nxt = center_r;
    last_nxt   = last_r;
    status_nxt = status_r;
    src_nxt    = src_r;
    cmd        = '0;
    cmd.iter   = cnt_r[ITER_W-1:0];
    cmd.sel    = sel_r;
    cmd.src    = src_r;
    cmd.center = center_r;
    cmd.idx    = k_r;
    cmd.last   = last_r;
    cmd.status = status_r;
    cmd.cmul   = (act_r == ACT_CURV);
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load   = 1'b1;
          act_nxt    = action;
          ord_nxt    = order;
          cnt_nxt    = '0;
          k_nxt      = '0;
          status_nxt = ST_OK;
          state_nxt  = S_CORD;
        end
      end
      S_CORD: begin
        cmd.cstep = 1'b1;
        if (cnt_r == CNT_W'(CORDIC_STEPS - 1)) begin
          state_nxt = S_SCALE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_SCALE: begin
        cmd.scale = 1'b1;
        state_nxt = S_DISP;
      end
      S_DISP: begin
        last_nxt   = 1'b1;
        center_nxt = 1'b0;
        src_nxt    = SRC_COMB;
        if ((act_r == ACT_DERIV || act_r == ACT_CURV) && sts.rad_zero) begin
          status_nxt = ST_RAD;
          src_nxt    = SRC_ZERO;
          state_nxt  = S_PUT;
        end else begin
          unique case (act_r)
            ACT_POINT: begin
              sel_nxt    = SEL_CS;
              center_nxt = 1'b1;
              state_nxt  = S_MUL;
            end
            ACT_TANG: begin
              sel_nxt   = SEL_NSC;
              state_nxt = S_MUL;
            end
            ACT_CURV: begin
              src_nxt   = SRC_QUO;
              state_nxt = S_MUL;
            end
            default: begin
              if (ord_bad) begin
                status_nxt = ST_ORD;
                src_nxt    = SRC_ZERO;
                state_nxt  = S_PUT;
              end else begin
                sel_nxt    = SEL_CS;
                center_nxt = 1'b1;
                last_nxt   = (ord_r[IDX_W-1:0] == '0);
                state_nxt  = S_MUL;
              end
            end
          endcase
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        cnt_nxt = '0;
        state_nxt = (act_r == ACT_CURV) ? S_DINIT : S_PUT;
      end
      S_DINIT: begin
        cmd.dinit = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.dstep = 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = S_PUT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        if (!sts.out_busy) begin
          cmd.oload = 1'b1;
          if (last_r) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt      = k_r + 1'b1;
            sel_nxt    = k_nxt[1:0];
            center_nxt = 1'b0;
            last_nxt   = (k_nxt == ord_r[IDX_W-1:0]);
            state_nxt  = S_MUL;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    cnt_r    <= cnt_nxt;
    act_r    <= act_nxt;
    ord_r    <= ord_nxt;
    k_r      <= k_nxt;
    sel_r    <= sel_nxt;
    center_r <= center_nxt;
    last_r   <= last_nxt;
    status_r <= status_nxt;
    src_r    <= src_nxt;
  end

endmodule

`default_nettype wire

>>> src/cpde_dp.sv
// datapath: cordic, radius scaling, axis combination, divider, result register
// depends on cpde_pkg
`default_nettype none

module cpde_dp import cpde_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_t             cfg,
  input  wire cmd_t             cmd,
  input  wire logic [ANG_W-1:0] angle,
  output sts_t                  sts,
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [103:0]          out_tdata,
  output logic                  out_tlast,
  output logic [1:0]            out_tuser
);

  logic [1:0]               quad_r;
  logic signed [CS_W-1:0]   x_r, y_r, z_r;
  logic signed [TRIG_W-1:0] co_r, si_r, co_c, si_c;
  logic signed [COEF_W-1:0] c_r, s_r, c_c, s_c, a_c, b_c;
  logic signed [PROD_W-1:0] pa_r [3];
  logic signed [PROD_W-1:0] pb_r [3];
  logic [DIV_STEPS-1:0]     quo_r [3];
  logic [43:0]              rem_r [3];
  logic                     neg_r [3];
  logic                     out_valid_r;
  logic [VEC_W-1:0]         vec_c [3];

  logic [44:0]              zprod;
  logic [45:0]              zsum;
  logic signed [CS_W-1:0]   z0, dx, dy, at;
  logic signed [TRIG_W-1:0] xe, ye;
  logic signed [67:0]       pc, ps;
  logic [43:0]              dval;

  assign zprod = angle[13:0] * PI_Q29;
  assign zsum  = {1'b0, zprod} + 46'd8192;
  assign z0    = $signed({2'b00, zsum[45:14]});
  assign dx    = y_r >>> cmd.iter;
  assign dy    = x_r >>> cmd.iter;
  assign at    = $signed({3'b000, atan_q30(cmd.iter)});
  assign xe    = x_r;
  assign ye    = y_r;
  assign dval  = {cfg.rad, 12'd0};

  // quadrant fold of cordic output
  always_comb begin
    unique case (quad_r)
      2'd0: begin co_c = xe;  si_c = ye;  end
      2'd1: begin co_c = -ye; si_c = xe;  end
      2'd2: begin co_c = -xe; si_c = -ye; end
      default: begin co_c = ye; si_c = -xe; end
    endcase
    pc  = co_c * $signed({1'b0, cfg.rad});
    ps  = si_c * $signed({1'b0, cfg.rad});
    c_c = COEF_W'((pc + (68'sd1 <<< 29)) >>> 30);
    s_c = COEF_W'((ps + (68'sd1 <<< 29)) >>> 30);
  end

  always_comb begin
    if (cmd.cmul) begin
      a_c = co_r;
      b_c = si_r;
    end else begin
      unique case (cmd.sel)
        SEL_CS:   begin a_c = c_r;  b_c = s_r;  end
        SEL_NSC:  begin a_c = -s_r; b_c = c_r;  end
        SEL_NCNS: begin a_c = -c_r; b_c = -s_r; end
        default:  begin a_c = s_r;  b_c = -c_r; end
      endcase
    end
  end

  // per-component result of the current request
  always_comb begin
    logic signed [PROD_W:0]     sum;
    logic signed [38:0]         rnd;
    logic signed [WIDE_W-1:0]   w;
    logic signed [VEC_W-1:0]    cen;
    for (int j = 0; j < 3; j++) begin
      sum = pa_r[j] + pb_r[j];
      rnd = 39'((sum + 53'sd8192) >>> 14);
      cen = (j == 0) ? cfg.cx : ((j == 1) ? cfg.cy : cfg.cz);
      w   = rnd;
      if (cmd.center) w = w + cen;
      unique case (cmd.src)
        SRC_COMB: vec_c[j] = sat32(w);
        SRC_QUO: begin
          w = $signed({1'b0, quo_r[j]});
          vec_c[j] = neg_r[j] ? sat32(w) : sat32(-w);
        end
        default: vec_c[j] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quad_r <= angle[15:14];
      x_r    <= $signed({4'd0, GAIN_Q30});
      y_r    <= '0;
      z_r    <= z0;
    end else if (cmd.cstep) begin
      if (!z_r[CS_W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
    if (cmd.scale) begin
      co_r <= co_c;
      si_r <= si_c;
      c_r  <= c_c;
      s_r  <= s_c;
    end
    for (int j = 0; j < 3; j++) begin
      if (cmd.mul) begin
        pa_r[j] <= $signed(cfg.ax[16*j +: 16]) * a_c;
        pb_r[j] <= $signed(cfg.ay[16*j +: 16]) * b_c;
      end
    end
    for (int j = 0; j < 3; j++) begin
      logic signed [PROD_W:0] num;
      logic [PROD_W:0]        mag;
      logic [44:0]            t;
      num = pa_r[j] + pb_r[j];
      mag = num[PROD_W] ? -num : num;
      t   = {rem_r[j], quo_r[j][DIV_STEPS-1]};
      if (cmd.dinit) begin
        neg_r[j] <= num[PROD_W];
        quo_r[j] <= DIV_STEPS'(mag) + DIV_STEPS'({cfg.rad, 11'd0});
        rem_r[j] <= '0;
      end else if (cmd.dstep) begin
        if (t >= {1'b0, dval}) begin
          rem_r[j] <= 44'(t - {1'b0, dval});
          quo_r[j] <= {quo_r[j][DIV_STEPS-2:0], 1'b1};
        end else begin
          rem_r[j] <= t[43:0];
          quo_r[j] <= {quo_r[j][DIV_STEPS-2:0], 1'b0};
        end
      end
    end
    if (cmd.oload) begin
      out_tdata <= {2'b00, cmd.idx, vec_c[2], vec_c[1], vec_c[0]};
      out_tlast <= cmd.last;
      out_tuser <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.oload) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign sts.out_busy = out_valid_r && !out_tready;
  assign sts.rad_zero = (cfg.rad == '0);

endmodule

`default_nettype wire

>>> src/circle_point_derivative_eval.sv
// request to result: cordic, radius scaling, dispatch, one combine multiply, result load; curvature
// adds the divider before the load, and a derivative run repeats multiply + load per further result
// the cordic has 16 steps and the bit-serial divider 48 steps
// one request at a time: next request taken the cycle after the last result is loaded, and
// each result load waits while the output is stalled
// rst_n synchronous active low: controller idle, output empty, registers to unit circle
`default_nettype none

`include "circle_point_derivative_eval_macros.svh"

module circle_point_derivative_eval import cpde_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // angle[15:0], order[22:16], zero pad
  input  wire logic [1:0]  in_tuser,   // action
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [103:0]     out_tdata,  // vec_x, vec_y, vec_z, deriv_index, zero pad
  output logic             out_tlast,  // last
  output logic [1:0]       out_tuser,  // status
  // register writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [47:0] cfg_data
);

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  // register file, writes always taken; unknown indexes dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cx  <= '0;
      cfg_r.cy  <= '0;
      cfg_r.cz  <= '0;
      cfg_r.ax  <= 48'd16384;       // x = 1.0
      cfg_r.ay  <= 48'd1073741824;  // y = 1.0
      cfg_r.rad <= 32'd65536;       // 1.0
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CX:  cfg_r.cx  <= cfg_data[31:0];
        CFG_CY:  cfg_r.cy  <= cfg_data[31:0];
        CFG_CZ:  cfg_r.cz  <= cfg_data[31:0];
        CFG_AX:  cfg_r.ax  <= cfg_data;
        CFG_AY:  cfg_r.ay  <= cfg_data;
        CFG_RAD: cfg_r.rad <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // sequencer: cordic steps, dispatch by action, derivative loop, divider steps
  cpde_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .action    (in_tuser),
    .order     (in_tdata[22:16]),
    .sts       (sts),
    .cmd       (cmd)
  );

  // arithmetic and the result register
  cpde_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .cmd        (cmd),
    .angle      (in_tdata[15:0]),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  // busy right after a request is taken
  `CPDE_ASSERT_NEXT(a_busy_after_req, clk, rst_n, in_tvalid && in_tready, !in_tready)
  // error results always close their request
  `CPDE_ASSERT_NOW(a_err_last, clk, rst_n, out_tvalid && out_tuser != ST_OK, out_tlast)
  // error results carry derivative index zero
  `CPDE_ASSERT_NOW(a_err_idx, clk, rst_n, out_tvalid && out_tuser != ST_OK,
                   out_tdata[101:96] == 6'd0)

endmodule

`default_nettype wire
